/* rtl/core/spc_pkg.sv */
// spc_pkg: widths, output codes and result beat types of the swing point confirmer
// no dependencies; imported by every module of the block
package spc_pkg;

	localparam int PRICE_BITS   = 32;
	localparam int INDEX_BITS   = 32;
	localparam int RETRACE_BITS = 16;

	localparam logic [RETRACE_BITS-1:0] RETRACE_RESET = RETRACE_BITS'(2);

	// out_kind codes
	localparam logic KIND_APPEND  = 1'b0;
	localparam logic KIND_REPLACE = 1'b1;

	// result queue: room for the two beats one point can cause, plus slack
	localparam int FIFO_DEPTH = 4;
	localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
	localparam int FIFO_CW    = FIFO_AW + 1;

	typedef struct packed {
		logic                  kind;
		logic                  high;
		logic [PRICE_BITS-1:0] price;
		logic [INDEX_BITS-1:0] index;
		logic                  run_end;
	} result_t;

	// up to two beats written in one cycle, r0 first
	typedef struct packed {
		logic [1:0] cnt;
		result_t    r0;
		result_t    r1;
	} fifo_wr_t;

endpackage

/* rtl/core/spc_fifo.sv */
// spc_fifo: small result queue taking up to two beats a cycle, one beat out a cycle while rd_stall is low
// depends on spc_pkg
module spc_fifo
	import spc_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  fifo_wr_t wr,
	output logic     full2,
	output logic     rd_valid,
	input  logic     rd_stall,
	output result_t  rd_data
);

	result_t              mem_q [FIFO_DEPTH];
	logic [FIFO_AW-1:0]   wr_ptr_q;
	logic [FIFO_AW-1:0]   rd_ptr_q;
	logic [FIFO_CW-1:0]   count_q;
	logic                 pop;
	logic [FIFO_AW-1:0]   wr_ptr_p1;

	assign rd_valid  = (count_q != '0);
	assign rd_data   = mem_q[rd_ptr_q];
	assign pop       = rd_valid && !rd_stall;
	// fewer than two free slots: hold off the input side
	assign full2     = (count_q > FIFO_CW'(FIFO_DEPTH - 2));
	assign wr_ptr_p1 = wr_ptr_q + FIFO_AW'(1);

	always_ff @(posedge clk) begin
		if (wr.cnt != 2'd0) begin
			mem_q[wr_ptr_q] <= wr.r0;
		end
		if (wr.cnt == 2'd2) begin
			mem_q[wr_ptr_p1] <= wr.r1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + FIFO_AW'(wr.cnt);
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + FIFO_AW'(1);
			end
			count_q <= count_q + FIFO_CW'(wr.cnt) - FIFO_CW'(pop);
		end
	end

endmodule

/* rtl/core/swing_point_confirmer.sv */
// swing_point_confirmer: confirms alternating turning points from a swing point stream
// depends on spc_pkg and spc_fifo
//
// Input channel (in_valid / in_stall) carries one swing point a beat: is_high, price,
// bar_index and stream_end. Output channel (out_valid / out_stall) carries turning
// point beats: out_kind (append or replace), out_high, out_price, out_index and
// run_end, which marks the last beat caused by one input point. A point causes
// zero, one or two beats.
// Each point is evaluated in the cycle it is accepted against the confirmed and
// candidate registers; its beats are registered into a four-entry result queue whose
// head drives the output. One point can be accepted every cycle while in_stall is
// low; the output drains one beat a cycle while out_stall is low, so the two beats of
// one point leave one after the other. in_stall rises while the queue has fewer than
// two free slots, so a stalled receiver backs up into in_stall once three beats are
// queued; queued beats hold steady on the outputs while out_stall is high. The user
// must write min_retrace_bars through cfg_we / cfg_data only while the block is idle;
// the block does not enforce this. Reset empties the queue, clears the confirmed and
// candidate points and sets min_retrace_bars to 2. stream_end clears the state again.
module swing_point_confirmer
	import spc_pkg::*;
(
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    cfg_we,
	input  logic [RETRACE_BITS-1:0] cfg_data,
	input  logic                    in_valid,
	output logic                    in_stall,
	input  logic                    is_high,
	input  logic [PRICE_BITS-1:0]   price,
	input  logic [INDEX_BITS-1:0]   bar_index,
	input  logic                    stream_end,
	output logic                    out_valid,
	input  logic                    out_stall,
	output logic                    out_kind,
	output logic                    out_high,
	output logic [PRICE_BITS-1:0]   out_price,
	output logic [INDEX_BITS-1:0]   out_index,
	output logic                    run_end
);

	logic [RETRACE_BITS-1:0] min_retrace_q;

	logic                  have_conf_q, conf_high_q;
	logic [PRICE_BITS-1:0] conf_price_q;
	logic [INDEX_BITS-1:0] conf_index_q;
	logic                  have_cand_q, cand_high_q;
	logic [PRICE_BITS-1:0] cand_price_q;
	logic [INDEX_BITS-1:0] cand_index_q;

	logic                  have_conf_d, conf_high_d;
	logic [PRICE_BITS-1:0] conf_price_d;
	logic [INDEX_BITS-1:0] conf_index_d;
	logic                  have_cand_d, cand_high_d;
	logic [PRICE_BITS-1:0] cand_price_d;
	logic [INDEX_BITS-1:0] cand_index_d;

	logic                  accept;
	logic                  step_v, tail_v, ok;
	result_t               step_r, tail_r;
	logic [INDEX_BITS-1:0] bar_gap;
	fifo_wr_t              wr;
	result_t               head;

	function automatic logic beyond(input logic hi, input logic [PRICE_BITS-1:0] a,
	                                input logic [PRICE_BITS-1:0] b);
		return hi ? (a > b) : (a < b);
	endfunction

	assign accept  = in_valid && !in_stall;
	assign bar_gap = bar_index - cand_index_q;

	always_comb begin
		have_conf_d  = have_conf_q;
		conf_high_d  = conf_high_q;
		conf_price_d = conf_price_q;
		conf_index_d = conf_index_q;
		have_cand_d  = have_cand_q;
		cand_high_d  = cand_high_q;
		cand_price_d = cand_price_q;
		cand_index_d = cand_index_q;
		step_v       = 1'b0;
		step_r       = '{kind: KIND_APPEND, high: is_high, price: price, index: bar_index,
		                 run_end: 1'b0};
		ok           = beyond(is_high, price, conf_price_q) ||
		               ((bar_index >= cand_index_q) &&
		                (bar_gap >= INDEX_BITS'(min_retrace_q)));

		if (!have_conf_q) begin
			// first point of a stream goes straight out
			step_v       = 1'b1;
			have_conf_d  = 1'b1;
			conf_high_d  = is_high;
			conf_price_d = price;
			conf_index_d = bar_index;
		end else if (is_high != conf_high_q) begin
			if (!have_cand_q || beyond(is_high, price, cand_price_q)) begin
				have_cand_d  = 1'b1;
				cand_high_d  = is_high;
				cand_price_d = price;
				cand_index_d = bar_index;
			end
		end else if (have_cand_q) begin
			if (ok) begin
				// candidate confirmed, this point becomes the next candidate
				step_v       = 1'b1;
				step_r.high  = cand_high_q;
				step_r.price = cand_price_q;
				step_r.index = cand_index_q;
				conf_high_d  = cand_high_q;
				conf_price_d = cand_price_q;
				conf_index_d = cand_index_q;
				cand_high_d  = is_high;
				cand_price_d = price;
				cand_index_d = bar_index;
			end else if (beyond(is_high, price, conf_price_q)) begin
				step_v       = 1'b1;
				step_r.kind  = KIND_REPLACE;
				conf_price_d = price;
				conf_index_d = bar_index;
				have_cand_d  = 1'b0;
			end
		end else if (beyond(is_high, price, conf_price_q)) begin
			step_v       = 1'b1;
			step_r.kind  = KIND_REPLACE;
			conf_price_d = price;
			conf_index_d = bar_index;
		end

		// tail candidate, judged on the updated state
		tail_v = stream_end && have_cand_d && have_conf_d &&
		         (cand_high_d != conf_high_d) && (cand_index_d > conf_index_d);
		tail_r = '{kind: KIND_APPEND, high: cand_high_d, price: cand_price_d,
		           index: cand_index_d, run_end: 1'b1};

		if (stream_end) begin
			have_conf_d  = 1'b0;
			conf_high_d  = 1'b0;
			conf_price_d = '0;
			conf_index_d = '0;
			have_cand_d  = 1'b0;
			cand_high_d  = 1'b0;
			cand_price_d = '0;
			cand_index_d = '0;
		end

		step_r.run_end = !tail_v;
		wr.cnt = 2'd0;
		wr.r0  = tail_r;
		wr.r1  = tail_r;
		if (accept) begin
			if (step_v) begin
				wr.r0  = step_r;
				wr.cnt = tail_v ? 2'd2 : 2'd1;
			end else if (tail_v) begin
				wr.cnt = 2'd1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_retrace_q <= RETRACE_RESET;
			have_conf_q   <= 1'b0;
			conf_high_q   <= 1'b0;
			conf_price_q  <= '0;
			conf_index_q  <= '0;
			have_cand_q   <= 1'b0;
			cand_high_q   <= 1'b0;
			cand_price_q  <= '0;
			cand_index_q  <= '0;
		end else begin
			if (cfg_we) begin
				min_retrace_q <= cfg_data;
			end
			if (accept) begin
				have_conf_q  <= have_conf_d;
				conf_high_q  <= conf_high_d;
				conf_price_q <= conf_price_d;
				conf_index_q <= conf_index_d;
				have_cand_q  <= have_cand_d;
				cand_high_q  <= cand_high_d;
				cand_price_q <= cand_price_d;
				cand_index_q <= cand_index_d;
			end
		end
	end

	spc_fifo u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr       (wr),
		.full2    (in_stall),
		.rd_valid (out_valid),
		.rd_stall (out_stall),
		.rd_data  (head)
	);

	assign out_kind  = head.kind;
	assign out_high  = head.high;
	assign out_price = head.price;
	assign out_index = head.index;
	assign run_end   = head.run_end;

endmodule

/* rtl/core/spc_checker.sv */
// spc_checker: port-level checks on the swing point confirmer over time
// depends on spc_pkg; bound to swing_point_confirmer below
module spc_checker
	import spc_pkg::*;
(
	input logic                    clk,
	input logic                    arst_n,
	input logic                    in_stall,
	input logic                    out_valid,
	input logic                    out_stall,
	input logic                    out_kind,
	input logic                    out_high,
	input logic [PRICE_BITS-1:0]   out_price,
	input logic [INDEX_BITS-1:0]   out_index,
	input logic                    run_end
);

	// a stalled output beat holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_price) && $stable(out_index) &&
		$stable(out_kind) && $stable(out_high) && $stable(run_end))
		else $error("output beat changed under stall");

	// an empty queue never holds off the input
	a_empty_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> !in_stall)
		else $error("input stalled with nothing queued");

	// the first of two beats from one point is always an append
	a_pair_append: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !run_end |-> out_kind == KIND_APPEND)
		else $error("replace beat followed by another beat of the same point");

	// the second beat of a pair is already queued, is an append and alternates type
	a_pair_follow: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_stall && !run_end |=>
		out_valid && run_end && out_kind == KIND_APPEND && out_high != $past(out_high))
		else $error("tail beat missing or not alternating");

endmodule

bind swing_point_confirmer spc_checker u_spc_checker (.*);
